[design/gvr_pkg.sv]
// Package: shared constants, types and sequencer states for the variance recursion unit.
package gvr_pkg;

  localparam int unsigned DefaultArchLags  = 1;
  localparam int unsigned DefaultAsymLags  = 1;
  localparam int unsigned DefaultGarchLags = 1;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LogFracW  = 40;
  localparam int unsigned LogW      = 47;

  localparam logic [RegIdxW-1:0] RegOmega    = 3'd0;
  localparam logic [RegIdxW-1:0] RegAlpha1   = 3'd1;
  localparam logic [RegIdxW-1:0] RegAlpha2   = 3'd2;
  localparam logic [RegIdxW-1:0] RegGamma1   = 3'd3;
  localparam logic [RegIdxW-1:0] RegGamma2   = 3'd4;
  localparam logic [RegIdxW-1:0] RegBeta1    = 3'd5;
  localparam logic [RegIdxW-1:0] RegBeta2    = 3'd6;
  localparam logic [RegIdxW-1:0] RegBackcast = 3'd7;

  localparam logic [1:0] KindArch  = 2'd0;
  localparam logic [1:0] KindAsym  = 2'd1;
  localparam logic [1:0] KindGarch = 2'd2;

  localparam logic [63:0] Mask63      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Ln2Q62      = 64'h2C5C_85FD_F473_DE6A;
  localparam logic [63:0] ThousandQ32 = 64'd1000 << 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM,
    ST_DECIDE,
    ST_LOG_A,
    ST_LOG_B,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic series_start;
    logic [62:0] powered_resid;
    logic resid_negative;
    logic signed [63:0] var_floor;
    logic [62:0] var_ceiling;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] variance_out;
    logic clamped_low;
    logic compressed_high;
    logic overflowed;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [63:0] x;
  } log_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [LogW-1:0] value;
  } log_stat_t;

  function automatic logic [63:0] sat_add_pos(input logic [62:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > {1'b0, Mask63}) ? Mask63 : s[63:0];
  endfunction

endpackage

[design/gvr_if.sv]
// Interface: valid/ready channel carrying one item of a given payload type.
interface gvr_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/gvr_mul.sv]
// Shared multiplier: signed or unsigned 64x64 product built from four 32x32 partial products.
module gvr_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic is_signed,
  output logic done,
  output logic signed [127:0] product
);
  logic [63:0] ua, ub;
  logic neg;
  logic [2:0] step;
  logic busy;
  logic [127:0] acc;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;

  always_comb begin
    pa = step[1] ? ua[63:32] : ua[31:0];
    pb = step[0] ? ub[63:32] : ub[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    pp_sh = {64'd0, pp} << ({5'd0, step[1]} * 7'd32 + {5'd0, step[0]} * 7'd32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= !start && busy && (step == 3'd3);
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        ua <= (is_signed && a[63]) ? 64'd0 - a : a;
        ub <= (is_signed && b[63]) ? 64'd0 - b : b;
        neg <= is_signed && (a[63] ^ b[63]);
        acc <= '0;
      end else if (busy) begin
        acc <= acc + pp_sh;
        step <= step + 3'd1;
        if (step == 3'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign product = neg ? 128'sd0 - $signed(acc) : $signed(acc);
endmodule

[design/gvr_log2.sv]
// Log2 unit: normalize, then 40 squaring steps of four 32x32 partial products, Q.40 result.
module gvr_log2 (
  input  logic clk,
  input  logic rst,
  input  gvr_pkg::log_req_t req,
  output gvr_pkg::log_stat_t stat
);
  logic [63:0] m;
  logic [5:0] cnt;
  logic [1:0] sub;
  logic norm;
  logic [127:0] sq_part;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic [127:0] sq;
  logic [63:0] mq;
  logic [5:0] lz;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) lz = 6'(i);
    end
    pa = sub[1] ? m[63:32] : m[31:0];
    pb = sub[0] ? m[63:32] : m[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    pp_sh = {64'd0, pp} << ({5'd0, sub[1]} * 7'd32 + {5'd0, sub[0]} * 7'd32);
    sq = sq_part + pp_sh;
    mq = sq[125:62];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= !req.start && stat.busy && !norm && (sub == 2'd3) && (cnt == 6'd39);
      if (req.start) begin
        stat.busy <= 1'b1;
        m <= req.x;
        norm <= 1'b1;
        cnt <= 6'd0;
        sub <= 2'd0;
        sq_part <= '0;
        stat.value <= '0;
      end else if (stat.busy && norm) begin
        m <= m << (6'd62 - lz);
        stat.value <= {lz, 41'd0} >> 1;
        norm <= 1'b0;
      end else if (stat.busy) begin
        sub <= sub + 2'd1;
        if (sub != 2'd3) begin
          sq_part <= sq;
        end else begin
          sq_part <= '0;
          cnt <= cnt + 6'd1;
          if (mq[63]) begin
            m <= mq >> 1;
            stat.value[6'd39 - cnt] <= 1'b1;
          end else begin
            m <= mq;
          end
          if (cnt == 6'd39) stat.busy <= 1'b0;
        end
      end
    end
  end
endmodule

[design/garch_variance_recursion_unit.sv]
// Top level: GJR-GARCH conditional variance recursion with a shared multiplier and log2 unit.
// Each item is taken only while the sequencer is idle and no result is waiting, and
// yields one result. The sum of omega and up to six lag terms is built on one 64x64
// multiplier that works through four 32x32 partial products; a skipped term does not
// use it. The sum is followed by a decide state and a writeback state, and the next
// item is taken only after the last result has been taken. An item above its upper
// bound whose sum fits in 64 signed bits also runs two log2 passes (40 squaring steps
// of four partial products each) and a scaling product.
module garch_variance_recursion_unit #(
  parameter int unsigned ARCH_LAGS  = gvr_pkg::DefaultArchLags,
  parameter int unsigned ASYM_LAGS  = gvr_pkg::DefaultAsymLags,
  parameter int unsigned GARCH_LAGS = gvr_pkg::DefaultGarchLags
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [gvr_pkg::RegIdxW-1:0] cfg_index,
  input  logic [gvr_pkg::CfgDataW-1:0] cfg_data,
  gvr_if.sink   in_ch,
  gvr_if.source out_ch
);
  localparam int unsigned ArchN  = (ARCH_LAGS > 2) ? 2 : ARCH_LAGS;
  localparam int unsigned AsymN  = (ASYM_LAGS > 2) ? 2 : ASYM_LAGS;
  localparam int unsigned GarchN = (GARCH_LAGS > 2) ? 2 : GARCH_LAGS;

  logic [63:0] omega, alpha [2], gam [2], beta [2];
  logic [62:0] backcast;
  logic [62:0] past_resid [2];
  logic past_negative [2];
  logic [63:0] past_variance [2];
  logic [1:0] samples_seen;

  gvr_pkg::state_t state, state_next;
  gvr_pkg::in_item_t item;
  logic [1:0] seen;
  logic [2:0] term;
  logic j;
  logic [1:0] kind;
  logic [127:0] acc;
  logic [63:0] la;
  logic mul_start, mul_done, mul_busy, term_go;
  logic [63:0] mul_a, mul_b;
  logic mul_signed;
  logic signed [127:0] prod;
  logic shift33, use_term;
  gvr_pkg::log_req_t lreq;
  gvr_pkg::log_stat_t lstat;
  logic log_go;
  logic out_valid;
  gvr_pkg::out_item_t result;
  logic have;
  logic [127:0] addend;
  logic fits, less_low, above_up;
  logic [63:0] den, diff;

  gvr_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
    .is_signed(mul_signed), .done(mul_done), .product(prod));
  gvr_log2 u_log (.clk, .rst, .req(lreq), .stat(lstat));

  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= '0; backcast <= '0;
      alpha[0] <= '0; alpha[1] <= '0; gam[0] <= '0; gam[1] <= '0;
      beta[0] <= '0; beta[1] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gvr_pkg::RegOmega:    omega <= cfg_data;
        gvr_pkg::RegAlpha1:   alpha[0] <= cfg_data;
        gvr_pkg::RegAlpha2:   alpha[1] <= cfg_data;
        gvr_pkg::RegGamma1:   gam[0] <= cfg_data;
        gvr_pkg::RegGamma2:   gam[1] <= cfg_data;
        gvr_pkg::RegBeta1:    beta[0] <= cfg_data;
        gvr_pkg::RegBeta2:    beta[1] <= cfg_data;
        gvr_pkg::RegBackcast: backcast <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // term: bit 0 = lag, bits 2:1 = kind (0 arch, 1 asym, 2 garch)
  always_comb begin
    j = term[0];
    kind = term[2:1];
    have = seen > {1'b0, j};
    use_term = 1'b0;
    shift33 = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (kind)
      gvr_pkg::KindArch: begin
        use_term = {31'd0, j} < 32'(ArchN);
        mul_a = alpha[j];
        mul_b = have ? {1'b0, past_resid[j]} : {1'b0, backcast};
      end
      gvr_pkg::KindAsym: begin
        use_term = ({31'd0, j} < 32'(AsymN)) && (!have || past_negative[j]);
        shift33 = !have;
        mul_a = gam[j];
        mul_b = have ? {1'b0, past_resid[j]} : {1'b0, backcast};
      end
      gvr_pkg::KindGarch: begin
        use_term = {31'd0, j} < 32'(GarchN);
        mul_a = beta[j];
        mul_b = have ? past_variance[j] : {1'b0, backcast};
      end
      default: ;
    endcase
    if (state == gvr_pkg::ST_SCALE) begin
      mul_a = la;
      mul_b = gvr_pkg::Ln2Q62;
    end
    addend = shift33 ? 128'($signed(prod) >>> 33) : 128'($signed(prod) >>> 32);
    fits = acc[127:63] == {65{acc[63]}};
    less_low = $signed(acc) < $signed({{64{item.var_floor[63]}}, item.var_floor});
    above_up = $signed({65'd0, item.var_ceiling}) < $signed(acc);
    den = (item.var_ceiling == '0) ? 64'd1 : {1'b0, item.var_ceiling};
    diff = (la > {17'd0, lstat.value}) ? la - {17'd0, lstat.value} : 64'd0;
  end

  assign in_ch.ready = (state == gvr_pkg::ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = result;

  always_comb begin
    state_next = state;
    case (state)
      gvr_pkg::ST_IDLE:   if (in_ch.valid && in_ch.ready) state_next = gvr_pkg::ST_TERM;
      gvr_pkg::ST_TERM:   if (term == 3'd5 && (mul_done || !mul_busy && !use_term))
                            state_next = gvr_pkg::ST_DECIDE;
      gvr_pkg::ST_DECIDE: state_next = (!less_low && above_up && fits) ? gvr_pkg::ST_LOG_A
                                                                       : gvr_pkg::ST_DONE;
      gvr_pkg::ST_LOG_A:  if (lstat.done) state_next = gvr_pkg::ST_LOG_B;
      gvr_pkg::ST_LOG_B:  if (lstat.done) state_next = gvr_pkg::ST_SCALE;
      gvr_pkg::ST_SCALE:  if (mul_done) state_next = gvr_pkg::ST_DONE;
      gvr_pkg::ST_DONE:   state_next = gvr_pkg::ST_IDLE;
      default:            state_next = gvr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    term_go = (state == gvr_pkg::ST_TERM) && !mul_busy && use_term;
    mul_start = term_go || ((state == gvr_pkg::ST_SCALE) && !mul_busy && !log_go);
    mul_signed = (state == gvr_pkg::ST_TERM);
    lreq.start = ((state == gvr_pkg::ST_LOG_A) || (state == gvr_pkg::ST_LOG_B)) && log_go;
    lreq.x = (state == gvr_pkg::ST_LOG_A) ? acc[63:0] : den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gvr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      samples_seen <= '0;
      mul_busy <= 1'b0;
      log_go <= 1'b0;
      past_negative[0] <= 1'b0; past_negative[1] <= 1'b0;
      past_resid[0] <= '0; past_resid[1] <= '0;
      past_variance[0] <= '0; past_variance[1] <= '0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        gvr_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          item <= in_ch.data;
          seen <= in_ch.data.series_start ? 2'd0 : samples_seen;
          term <= 3'd0;
          acc <= {{64{omega[63]}}, omega};
        end
        gvr_pkg::ST_TERM: begin
          if (term_go) mul_busy <= 1'b1;
          if (mul_done) begin
            mul_busy <= 1'b0;
            acc <= acc + addend;
            term <= term + 3'd1;
          end else if (!mul_busy && !use_term) begin
            term <= term + 3'd1;
          end
          log_go <= 1'b1;
        end
        gvr_pkg::ST_DECIDE: begin
          result.clamped_low <= less_low;
          result.compressed_high <= 1'b0;
          result.overflowed <= !less_low && above_up && !fits;
          if (less_low) begin
            result.variance_out <= item.var_floor;
          end else if (above_up && !fits) begin
            result.variance_out <= gvr_pkg::sat_add_pos(item.var_ceiling, gvr_pkg::ThousandQ32);
          end else begin
            result.variance_out <= acc[63:0];
          end
        end
        gvr_pkg::ST_LOG_A: begin
          log_go <= lstat.done;
          if (lstat.done) la <= {17'd0, lstat.value};
        end
        gvr_pkg::ST_LOG_B: begin
          log_go <= lstat.done;
        end
        gvr_pkg::ST_SCALE: begin
          if (log_go) begin
            la <= diff;
            log_go <= 1'b0;
          end else if (mul_start) begin
            mul_busy <= 1'b1;
          end
          if (mul_done) begin
            mul_busy <= 1'b0;
            result.variance_out <= gvr_pkg::sat_add_pos(item.var_ceiling,
                                                        {6'd0, prod[127:70]});
            result.compressed_high <= 1'b1;
          end
        end
        gvr_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          past_resid[1] <= past_resid[0];
          past_resid[0] <= item.powered_resid;
          past_negative[1] <= past_negative[0];
          past_negative[0] <= item.resid_negative;
          past_variance[1] <= past_variance[0];
          past_variance[0] <= result.variance_out;
          samples_seen <= (seen == 2'd2) ? 2'd2 : seen + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("item accepted while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> $countones({result.clamped_low, result.compressed_high,
                                 result.overflowed}) <= 1)
    else $error("more than one outcome flag set");
  assert property (@(posedge clk) disable iff (rst)
    samples_seen != 2'd3)
    else $error("sample count past saturation");
endmodule

[tb/sv/tb_top.sv]
// Testbench for the GJR-GARCH variance recursion unit: random and directed items checked against an in-bench predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom  = 900;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gvr_pkg::RegIdxW-1:0] cfg_index = '0;
  logic [gvr_pkg::CfgDataW-1:0] cfg_data = '0;

  gvr_if #(.payload_t(gvr_pkg::in_item_t)) in_ch ();
  gvr_if #(.payload_t(gvr_pkg::out_item_t)) out_ch ();

  garch_variance_recursion_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [63:0] coef [gvr_pkg::NumRegs];
  logic [63:0] hist_resid [2];
  logic        hist_neg [2];
  logic [63:0] hist_var [2];
  int unsigned seen_cnt;

  gvr_pkg::in_item_t  pending_items [$];
  gvr_pkg::out_item_t expected_vars [$];
  phase_t    phase = PH_FREE;
  bit        hold_sink = 1'b0;
  bit        failed = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic logic signed [127:0] prod_floor(logic [63:0] a, logic [63:0] b, int sh);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    return p >>> sh;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int e;
    logic [63:0] m, res;
    logic [127:0] sq;
    e = 0;
    for (int k = 63; k >= 0; k--) begin
      if (x[k] && e == 0) e = k;
    end
    m = x << (62 - e);
    res = 64'(e) << 40;
    for (int i = 1; i <= 40; i++) begin
      sq = {64'd0, m} * {64'd0, m};
      m = sq[125:62];
      if (m[63]) begin
        m = m >> 1;
        res[40 - i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] add_cap(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, gvr_pkg::Mask63}) ? gvr_pkg::Mask63 : s[63:0];
  endfunction

  function automatic gvr_pkg::out_item_t predict_variance(gvr_pkg::in_item_t it);
    logic signed [127:0] acc, lo, up;
    logic [63:0] bc, den, la, lb, diff;
    logic [127:0] lp;
    gvr_pkg::out_item_t r;
    bit have;
    r = '0;
    bc = {1'b0, coef[gvr_pkg::RegBackcast][62:0]};
    if (it.series_start) seen_cnt = 0;
    acc = $signed({{64{coef[gvr_pkg::RegOmega][63]}}, coef[gvr_pkg::RegOmega]});
    have = seen_cnt > 0;
    acc += prod_floor(coef[gvr_pkg::RegAlpha1], have ? hist_resid[0] : bc, 32);
    if (!have) acc += prod_floor(coef[gvr_pkg::RegGamma1], bc, 33);
    else if (hist_neg[0]) acc += prod_floor(coef[gvr_pkg::RegGamma1], hist_resid[0], 32);
    acc += prod_floor(coef[gvr_pkg::RegBeta1], have ? hist_var[0] : bc, 32);
    lo = $signed({{64{it.var_floor[63]}}, it.var_floor});
    up = $signed({65'd0, it.var_ceiling});
    if (acc < lo) begin
      r.variance_out = it.var_floor;
      r.clamped_low = 1'b1;
    end else if (acc > up) begin
      if (acc > $signed(128'(gvr_pkg::Mask63))) begin
        r.variance_out = add_cap({1'b0, it.var_ceiling}, gvr_pkg::ThousandQ32);
        r.overflowed = 1'b1;
      end else begin
        den = it.var_ceiling == 0 ? 64'd1 : {1'b0, it.var_ceiling};
        la = log2_fix(acc[63:0]);
        lb = log2_fix(den);
        diff = la > lb ? la - lb : 64'd0;
        lp = {64'd0, diff} * {64'd0, gvr_pkg::Ln2Q62};
        r.variance_out = add_cap({1'b0, it.var_ceiling}, {6'd0, lp[127:70]});
        r.compressed_high = 1'b1;
      end
    end else begin
      r.variance_out = acc[63:0];
    end
    hist_resid[1] = hist_resid[0];
    hist_resid[0] = {1'b0, it.powered_resid};
    hist_neg[1] = hist_neg[0];
    hist_neg[0] = it.resid_negative;
    hist_var[1] = hist_var[0];
    hist_var[0] = r.variance_out;
    if (seen_cnt < 2) seen_cnt++;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic gvr_pkg::in_item_t rand_item(bit wild);
    gvr_pkg::in_item_t it;
    it.series_start = ($urandom_range(0, 15) == 0);
    it.resid_negative = 1'($urandom_range(0, 1));
    if (wild) begin
      it.powered_resid = 63'(rand64());
      it.var_floor = rand64();
      it.var_ceiling = 63'(rand64());
    end else begin
      it.powered_resid = 63'($urandom_range(0, 4000)) << 24;
      it.var_floor = $urandom_range(0, 3) == 0 ? -64'sd1 <<< 40 :
                     64'(($urandom_range(0, 1000)) << 16);
      it.var_ceiling = (63'($urandom_range(1, 200)) << 32) + 63'($urandom());
    end
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    bit go;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_vars.push_back(predict_variance(in_ch.data));
        void'(pending_items.pop_front());
      end
      go = pending_items.size() > 0;
      if (in_ch.valid && !in_ch.ready) go = 1'b1;
      else if (go && ((phase == PH_SRC_IDLE && $urandom_range(0, 99) < 46) ||
                      (phase == PH_BOTH && $urandom_range(0, 99) < 25)))
        go = 1'b0;
      in_ch.valid <= go;
      if (go) in_ch.data <= pending_items[0];
    end
  end

  // monitor
  always @(posedge clk) begin
    gvr_pkg::out_item_t got, exp_v;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_vars.size() == 0) begin
          $display("%0t unexpected result %h", $realtime, got);
          failed = 1'b1;
        end else begin
          exp_v = expected_vars.pop_front();
          if (got.variance_out !== exp_v.variance_out) begin
            $display("%0t variance_out expected %h actual %h", $realtime,
                     exp_v.variance_out, got.variance_out);
            failed = 1'b1;
          end
          if (got.clamped_low !== exp_v.clamped_low) begin
            $display("%0t clamped_low expected %b actual %b", $realtime,
                     exp_v.clamped_low, got.clamped_low);
            failed = 1'b1;
          end
          if (got.compressed_high !== exp_v.compressed_high) begin
            $display("%0t compressed_high expected %b actual %b", $realtime,
                     exp_v.compressed_high, got.compressed_high);
            failed = 1'b1;
          end
          if (got.overflowed !== exp_v.overflowed) begin
            $display("%0t overflowed expected %b actual %b", $realtime,
                     exp_v.overflowed, got.overflowed);
            failed = 1'b1;
          end
        end
      end
      out_ch.ready <= !hold_sink &&
        !((phase == PH_SNK_STALL && $urandom_range(0, 99) < 46) ||
          (phase == PH_BOTH && $urandom_range(0, 99) < 25));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [gvr_pkg::RegIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    coef[idx] = idx == gvr_pkg::RegBackcast ? (val & gvr_pkg::Mask63) : val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_vars.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_model(bit wild);
    write_reg(gvr_pkg::RegOmega, wild ? rand64() : 64'($urandom_range(0, 1 << 20)) << 12);
    write_reg(gvr_pkg::RegAlpha1, wild ? rand64() : 64'($urandom_range(0, 1 << 30)));
    write_reg(gvr_pkg::RegAlpha2, rand64());
    write_reg(gvr_pkg::RegGamma1, wild ? rand64() : 64'($urandom_range(0, 1 << 30)));
    write_reg(gvr_pkg::RegGamma2, rand64());
    write_reg(gvr_pkg::RegBeta1,
              wild ? rand64() : 64'($urandom_range(0, 1 << 31)) + (64'd1 << 31));
    write_reg(gvr_pkg::RegBackcast,
              wild ? rand64() : 64'($urandom_range(1, 1 << 20)) << 16);
  endtask

  initial begin
    gvr_pkg::in_item_t it;
    for (int i = 0; i < gvr_pkg::NumRegs; i++) coef[i] = '0;
    hist_resid = '{default: '0};
    hist_neg = '{default: 1'b0};
    hist_var = '{default: '0};
    seen_cnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, clamp, compress, overflow, zero upper bound
    write_reg(gvr_pkg::RegOmega, 64'sd5 <<< 32);
    write_reg(gvr_pkg::RegAlpha1, 64'd1 << 31);
    write_reg(gvr_pkg::RegAlpha2, 64'h8000_0000_0000_0000);
    write_reg(gvr_pkg::RegGamma1, 64'd1 << 30);
    write_reg(gvr_pkg::RegGamma2, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(gvr_pkg::RegBeta1, 64'd3 << 30);
    write_reg(gvr_pkg::RegBeta2, '1);
    write_reg(gvr_pkg::RegBackcast, gvr_pkg::Mask63);
    it = '{1'b1, '1, 1'b1, 64'h8000_0000_0000_0000, '1};
    pending_items.push_back(it);
    it = '{1'b0, '0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 63'd1};
    pending_items.push_back(it);
    it = '{1'b0, 63'd1 << 40, 1'b1, '0, 63'd1 << 32};
    pending_items.push_back(it);
    it = '{1'b0, '1, 1'b1, 64'h8000_0000_0000_0000, 63'd0};
    pending_items.push_back(it);
    it = '{1'b1, 63'd1 << 33, 1'b0, -64'sd1, 63'd1};
    pending_items.push_back(it);
    it = '{1'b0, 63'd7 << 32, 1'b1, '0, '1};
    pending_items.push_back(it);
    drain();
    write_reg(gvr_pkg::RegBackcast, 64'd2 << 32);
    write_reg(gvr_pkg::RegOmega, 64'h8000_0000_0000_0000);
    for (int i = 0; i < 8; i++) pending_items.push_back(rand_item(i[0]));
    it = '{1'b1, 63'd3 << 32, 1'b1, -64'sd1 <<< 62, 63'd1 << 20};
    pending_items.push_back(it);
    drain();

    for (int p = 0; p < 8; p++) begin
      phase = phase_t'(p % 4);
      set_model(p == 3 || p == 7);
      if (p == 2) fork
        begin
          hold_sink = 1'b1;
          repeat (400) @(posedge clk);
          hold_sink = 1'b0;
        end
      join_none
      for (int i = 0; i < NumRandom / 8; i++)
        pending_items.push_back(rand_item($urandom_range(0, 4) == 0 || p == 3));
      drain();
    end

    repeat (200) @(posedge clk);
    if (!failed && expected_vars.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

[sim.f]
design/gvr_pkg.sv
design/gvr_if.sv
design/gvr_mul.sv
design/gvr_log2.sv
design/garch_variance_recursion_unit.sv
tb/sv/tb_top.sv
